// ----- rtl/hali_pkg.sv -----
`default_nettype none

package hali_pkg;

    localparam int HOLD_W     = 16;
    localparam int BRIGHT_W   = 8;
    localparam int LIT_W      = 8;
    localparam int PROD_W     = HOLD_W + LIT_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int IN_W       = 8;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int LED_COUNT_DEFAULT = 10;

    localparam logic [HOLD_W-1:0]   SAT16            = 16'hFFFF;
    localparam logic [HOLD_W-1:0]   HOLD_TIME_RST    = 16'd1500;
    localparam logic [BRIGHT_W-1:0] BASE_BRIGHT_RST  = 8'd32;
    localparam logic [BRIGHT_W-1:0] FLASH_BRIGHT_RST = 8'd255;
    localparam logic [HOLD_W-1:0]   FLASH_MS_RST     = 16'd100;
    localparam logic [HOLD_W-1:0]   SHORT_GAP_RST    = 16'd100;
    localparam logic [HOLD_W-1:0]   LONG_GAP_RST     = 16'd1500;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BRIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_BRIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_GAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP     = 3'd5;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_ARMED    = 2'd1;
    localparam logic [1:0] MODE_IGNITION = 2'd2;

    localparam logic [2:0] REQ_NONE           = 3'd0;
    localparam logic [2:0] REQ_ARM_PRESS      = 3'd1;
    localparam logic [2:0] REQ_ARM_RELEASE    = 3'd2;
    localparam logic [2:0] REQ_LAUNCH_PRESS   = 3'd3;
    localparam logic [2:0] REQ_LAUNCH_RELEASE = 3'd4;

    localparam logic [2:0] PIC_IDLE       = 3'd0;
    localparam logic [2:0] PIC_ARMED      = 3'd1;
    localparam logic [2:0] PIC_IGNITION   = 3'd2;
    localparam logic [2:0] PIC_ARM_BAR    = 3'd3;
    localparam logic [2:0] PIC_LAUNCH_BAR = 3'd4;
    localparam logic [2:0] PIC_KEEP       = 3'd5;

    localparam logic [1:0] PHASE_FLASH_A = 2'd0;
    localparam logic [1:0] PHASE_SHORT   = 2'd1;
    localparam logic [1:0] PHASE_FLASH_B = 2'd2;
    localparam logic [1:0] PHASE_LONG    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_LIT,
        ST_DONE
    } seq_state_t;

endpackage

`default_nettype wire

// ----- rtl/hold_to_arm_launch_interlock.sv -----
// Each accepted input beat goes from ST_IDLE to ST_DONE when no bar is drawn, or through
// ST_MUL, the shared shift-subtract divider (24 steps) and ST_LIT when the bar length is computed.
// The input is not ready while an item is in work, and ST_DONE waits until the output
// register is free; one result can wait in the output register.
// Reset (rst_n, asynchronous, active low) clears the interlock to idle with timers
// stopped and loads the default configuration.
`default_nettype none

module hold_to_arm_launch_interlock #(
    parameter int LED_COUNT = hali_pkg::LED_COUNT_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tick[0], req_type[3:1], igniter_connected[4], zero[7:5]
    input  wire logic [hali_pkg::IN_W-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // mode[1:0], fire[2], holding[3], strip_picture[6:4], lit_count[14:7],
    // brightness[22:15], zero[23]
    output logic [hali_pkg::OUT_W-1:0]            m_axis_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hali_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hali_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hali_pkg::*;

    localparam logic [LIT_W-1:0]  LED_N  = LIT_W'(LED_COUNT);
    localparam logic [LIT_W-1:0]  LED_M1 = LIT_W'(LED_COUNT - 1);
    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic [HOLD_W-1:0]   hold_time_reg, flash_ms_reg, short_gap_reg, long_gap_reg;
    logic [BRIGHT_W-1:0] base_bright_reg, flash_bright_reg;

    logic [1:0]        mode_reg, mode_next;
    logic              ign_seen_reg, ign_seen_next;
    logic              hold_active_reg, hold_active_next;
    logic              timer_valid_reg, timer_valid_next;
    logic [HOLD_W-1:0] hold_elapsed_reg, hold_elapsed_next;
    logic [1:0]        blink_phase_reg, blink_phase_next;
    logic [HOLD_W-1:0] blink_elapsed_reg, blink_elapsed_next;

    logic [2:0]          res_pic_reg, res_pic_next;
    logic [BRIGHT_W-1:0] res_bright_reg, res_bright_next;
    logic [LIT_W-1:0]    lit_reg, lit_next, lit_direct;
    logic                need_div;
    logic [HOLD_W-1:0]   span;

    seq_state_t          state_reg, state_next;
    logic [PROD_W-1:0]   quot_reg, quot_next;
    logic [HOLD_W:0]     rem_reg, rem_next, rem_shift;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    logic       in_tick, in_conn, accept;
    logic [2:0] in_req;

    assign in_tick = s_axis_tdata[0];
    assign in_req  = s_axis_tdata[3:1];
    assign in_conn = s_axis_tdata[4];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg    <= HOLD_TIME_RST;
            base_bright_reg  <= BASE_BRIGHT_RST;
            flash_bright_reg <= FLASH_BRIGHT_RST;
            flash_ms_reg     <= FLASH_MS_RST;
            short_gap_reg    <= SHORT_GAP_RST;
            long_gap_reg     <= LONG_GAP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOLD_TIME:    hold_time_reg    <= cfg_data;
                REG_BASE_BRIGHT:  base_bright_reg  <= cfg_data[BRIGHT_W-1:0];
                REG_FLASH_BRIGHT: flash_bright_reg <= cfg_data[BRIGHT_W-1:0];
                REG_FLASH_MS:     flash_ms_reg     <= cfg_data;
                REG_SHORT_GAP:    short_gap_reg    <= cfg_data;
                REG_LONG_GAP:     long_gap_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        mode_next          = mode_reg;
        ign_seen_next      = ign_seen_reg;
        hold_active_next   = hold_active_reg;
        timer_valid_next   = timer_valid_reg;
        hold_elapsed_next  = hold_elapsed_reg;
        blink_phase_next   = blink_phase_reg;
        blink_elapsed_next = blink_elapsed_reg;

        if (in_tick)
        begin
            if (timer_valid_next && hold_elapsed_next != SAT16)
            begin
                hold_elapsed_next = hold_elapsed_next + 1'b1;
            end
            if (blink_elapsed_next != SAT16)
            begin
                blink_elapsed_next = blink_elapsed_next + 1'b1;
            end
        end

        case (in_req)
            REQ_ARM_PRESS:
            begin
                if (mode_next == MODE_IDLE)
                begin
                    hold_active_next  = 1'b1;
                    timer_valid_next  = 1'b1;
                    hold_elapsed_next = '0;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                end
            end
            REQ_ARM_RELEASE:
            begin
                mode_next = (mode_next == MODE_IDLE && timer_valid_next
                             && hold_elapsed_next > hold_time_reg) ? MODE_ARMED : MODE_IDLE;
                hold_active_next  = 1'b0;
                timer_valid_next  = 1'b0;
                hold_elapsed_next = '0;
            end
            REQ_LAUNCH_PRESS:
            begin
                if (mode_next == MODE_ARMED)
                begin
                    hold_active_next  = 1'b1;
                    timer_valid_next  = 1'b1;
                    hold_elapsed_next = '0;
                end
            end
            REQ_LAUNCH_RELEASE:
            begin
                if (mode_next == MODE_ARMED && timer_valid_next
                    && hold_elapsed_next > hold_time_reg)
                begin
                    mode_next = MODE_IGNITION;
                end
                hold_active_next  = 1'b0;
                timer_valid_next  = 1'b0;
                hold_elapsed_next = '0;
            end
            default: ;
        endcase
        if (in_req inside {[REQ_ARM_PRESS:REQ_LAUNCH_RELEASE]})
        begin
            ign_seen_next = 1'b0;
        end

        if (!in_conn && mode_next != MODE_IGNITION)
        begin
            mode_next         = MODE_IDLE;
            hold_active_next  = 1'b0;
            timer_valid_next  = 1'b0;
            hold_elapsed_next = '0;
        end

        if (mode_next == MODE_IGNITION)
        begin
            if (!ign_seen_next)
            begin
                hold_active_next  = 1'b1;
                timer_valid_next  = 1'b1;
                hold_elapsed_next = '0;
            end
            else if (timer_valid_next && hold_elapsed_next > hold_time_reg)
            begin
                mode_next         = MODE_IDLE;
                hold_active_next  = 1'b0;
                timer_valid_next  = 1'b0;
                hold_elapsed_next = '0;
            end
        end

        case (blink_phase_reg)
            PHASE_FLASH_A:
            begin
                res_bright_next = flash_bright_reg;
                span            = flash_ms_reg;
            end
            PHASE_SHORT:
            begin
                res_bright_next = base_bright_reg;
                span            = short_gap_reg;
            end
            PHASE_FLASH_B:
            begin
                res_bright_next = flash_bright_reg;
                span            = flash_ms_reg;
            end
            default:
            begin
                res_bright_next = base_bright_reg;
                span            = long_gap_reg;
            end
        endcase
        if (blink_elapsed_next > span)
        begin
            blink_elapsed_next = '0;
            blink_phase_next   = blink_phase_reg + 1'b1;
        end

        need_div   = 1'b0;
        lit_direct = '0;
        if (hold_active_next)
        begin
            case (mode_next)
                MODE_IDLE:  res_pic_next = PIC_ARM_BAR;
                MODE_ARMED: res_pic_next = PIC_LAUNCH_BAR;
                default:    res_pic_next = PIC_KEEP;
            endcase
            if (res_pic_next != PIC_KEEP)
            begin
                if (hold_time_reg == '0)
                begin
                    lit_direct = LED_N;
                end
                else
                begin
                    need_div = 1'b1;
                end
            end
        end
        else
        begin
            res_pic_next = {1'b0, mode_next};
        end

        ign_seen_next = (mode_next == MODE_IGNITION);
    end

    always_comb
    begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        lit_next       = lit_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        rem_shift      = {rem_reg[HOLD_W-1:0], quot_reg[PROD_W-1]};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lit_next   = lit_direct;
                    state_next = need_div ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                quot_next  = PROD_W'(hold_elapsed_reg) * PROD_W'(LED_M1);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, hold_time_reg})
                begin
                    rem_next  = rem_shift - {1'b0, hold_time_reg};
                    quot_next = {quot_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    quot_next = {quot_reg[PROD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_LIT;
                end
            end
            ST_LIT:
            begin
                lit_next   = (quot_reg >= PROD_W'(LED_M1)) ? LED_N
                                                            : quot_reg[LIT_W-1:0] + 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, res_bright_reg, lit_reg, res_pic_reg,
                                      hold_active_reg, (mode_reg == MODE_IGNITION),
                                      mode_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            ign_seen_reg      <= 1'b0;
            hold_active_reg   <= 1'b0;
            timer_valid_reg   <= 1'b0;
            hold_elapsed_reg  <= '0;
            blink_phase_reg   <= PHASE_FLASH_A;
            blink_elapsed_reg <= '0;
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                mode_reg          <= mode_next;
                ign_seen_reg      <= ign_seen_next;
                hold_active_reg   <= hold_active_next;
                timer_valid_reg   <= timer_valid_next;
                hold_elapsed_reg  <= hold_elapsed_next;
                blink_phase_reg   <= blink_phase_next;
                blink_elapsed_reg <= blink_elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        lit_reg      <= lit_next;
        out_data_reg <= out_data_next;
        if (accept)
        begin
            res_pic_reg    <= res_pic_next;
            res_bright_reg <= res_bright_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hali_checker.sv -----
`default_nettype none

module hali_checker #(
    parameter int LED_COUNT = hali_pkg::LED_COUNT_DEFAULT
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [hali_pkg::OUT_W-1:0]   m_axis_tdata
);
    import hali_pkg::*;

    logic [1:0]       o_mode;
    logic             o_fire;
    logic [2:0]       o_pic;
    logic [LIT_W-1:0] o_lit;

    assign o_mode = m_axis_tdata[1:0];
    assign o_fire = m_axis_tdata[2];
    assign o_pic  = m_axis_tdata[6:4];
    assign o_lit  = m_axis_tdata[14:7];

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    a_fire_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (o_fire == (o_mode == MODE_IGNITION)))
        else $error("fire line disagrees with mode");

    a_fire_picture: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && o_fire |->
            (o_pic == PIC_IGNITION || o_pic == PIC_KEEP) && o_lit == '0)
        else $error("ignition result shows a bar");

    a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (o_pic == PIC_ARM_BAR || o_pic == PIC_LAUNCH_BAR) |->
            o_lit != '0 && o_lit <= LIT_W'(LED_COUNT))
        else $error("bar length out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

endmodule

bind hold_to_arm_launch_interlock hali_checker #(
    .LED_COUNT(LED_COUNT)
) u_hali_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- sim/hold_to_arm_launch_interlock_tb.sv -----
`default_nettype none

module hold_to_arm_launch_interlock_tb;

    import hali_pkg::*;

    localparam int LEDS = hali_pkg::LED_COUNT_DEFAULT;

    typedef struct {
        logic [1:0] mode;
        logic       fire;
        logic       holding;
        logic [2:0] picture;
        logic [7:0] lit;
        logic [7:0] bright;
    } panel_t;

    // Tracks the interlock state and holds the panel outputs that each
    // accepted input beat should produce, oldest first.
    class interlock_tracker;
        logic [15:0] hold_time;
        logic [15:0] flash_len;
        logic [15:0] short_gap;
        logic [15:0] long_gap;
        logic [7:0]  base_bright;
        logic [7:0]  flash_bright;
        logic [1:0]  mode;
        logic [1:0]  phase;
        bit          seen;
        bit          timing;
        logic [15:0] held;
        logic [15:0] blink;
        panel_t      panel_due[$];
        int          fails;
        int          checked;
        int          accepted;
        int          armings;
        int          ignitions;

        function new();
            hold_time    = HOLD_TIME_RST;
            base_bright  = BASE_BRIGHT_RST;
            flash_bright = FLASH_BRIGHT_RST;
            flash_len    = FLASH_MS_RST;
            short_gap    = SHORT_GAP_RST;
            long_gap     = LONG_GAP_RST;
            mode         = MODE_IDLE;
            phase        = PHASE_FLASH_A;
            seen         = 1'b0;
            timing       = 1'b0;
            held         = '0;
            blink        = '0;
            fails        = 0;
            checked      = 0;
            accepted     = 0;
            armings      = 0;
            ignitions    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_HOLD_TIME:    hold_time    = val;
                REG_BASE_BRIGHT:  base_bright  = val[7:0];
                REG_FLASH_BRIGHT: flash_bright = val[7:0];
                REG_FLASH_MS:     flash_len    = val;
                REG_SHORT_GAP:    short_gap    = val;
                REG_LONG_GAP:     long_gap     = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return panel_due.size();
        endfunction

        function bit hold_done();
            return timing && (held > hold_time);
        endfunction

        function void set_timer(bit on);
            timing = on;
            held   = '0;
        endfunction

        function void note_beat(bit tick, logic [2:0] req, bit conn);
            panel_t      p;
            logic [15:0] span;
            int          bar;
            accepted++;
            if (tick)
            begin
                if (timing && held != SAT16)
                    held++;
                if (blink != SAT16)
                    blink++;
            end
            case (req)
                REQ_ARM_PRESS:
                begin
                    if (mode == MODE_IDLE)
                        set_timer(1'b1);
                    else
                        mode = MODE_IDLE;
                end
                REQ_ARM_RELEASE:
                begin
                    if (mode == MODE_IDLE && hold_done())
                    begin
                        mode = MODE_ARMED;
                        armings++;
                    end
                    else
                        mode = MODE_IDLE;
                    set_timer(1'b0);
                end
                REQ_LAUNCH_PRESS:
                begin
                    if (mode == MODE_ARMED)
                        set_timer(1'b1);
                end
                REQ_LAUNCH_RELEASE:
                begin
                    if (mode == MODE_ARMED && hold_done())
                    begin
                        mode = MODE_IGNITION;
                        ignitions++;
                    end
                    set_timer(1'b0);
                end
                default: ;
            endcase
            if (req >= REQ_ARM_PRESS && req <= REQ_LAUNCH_RELEASE)
                seen = 1'b0;
            if (!conn && mode != MODE_IGNITION)
            begin
                mode = MODE_IDLE;
                set_timer(1'b0);
            end
            if (mode == MODE_IGNITION)
            begin
                if (!seen)
                    set_timer(1'b1);
                else if (hold_done())
                begin
                    mode = MODE_IDLE;
                    set_timer(1'b0);
                end
            end
            case (phase)
                PHASE_FLASH_A, PHASE_FLASH_B:
                begin
                    p.bright = flash_bright;
                    span     = flash_len;
                end
                PHASE_SHORT:
                begin
                    p.bright = base_bright;
                    span     = short_gap;
                end
                default:
                begin
                    p.bright = base_bright;
                    span     = long_gap;
                end
            endcase
            if (blink > span)
            begin
                blink = '0;
                phase = phase + 2'd1;
            end
            p.lit = 8'd0;
            if (timing)
            begin
                case (mode)
                    MODE_IDLE:  p.picture = PIC_ARM_BAR;
                    MODE_ARMED: p.picture = PIC_LAUNCH_BAR;
                    default:    p.picture = PIC_KEEP;
                endcase
                if (p.picture != PIC_KEEP)
                begin
                    if (hold_time == 16'd0)
                        bar = LEDS;
                    else
                    begin
                        bar = int'(held) * (LEDS - 1) / int'(hold_time) + 1;
                        if (bar > LEDS)
                            bar = LEDS;
                    end
                    p.lit = bar[7:0];
                end
            end
            else
                p.picture = {1'b0, mode};
            seen      = (mode == MODE_IGNITION);
            p.mode    = mode;
            p.fire    = (mode == MODE_IGNITION);
            p.holding = timing;
            panel_due.push_back(p);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                fails++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_panel(logic [23:0] d);
            panel_t p;
            checked++;
            if (panel_due.size() == 0)
            begin
                fails++;
                $display("%0t: result beat %h arrived with nothing expected, actual %h",
                         $time, d, d);
                return;
            end
            p = panel_due.pop_front();
            check_field("mode", p.mode, d[1:0]);
            check_field("fire", p.fire, d[2]);
            check_field("holding", p.holding, d[3]);
            check_field("strip_picture", p.picture, d[6:4]);
            check_field("lit_count", p.lit, d[14:7]);
            check_field("brightness", p.bright, d[22:15]);
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    interlock_tracker tracker;
    logic [7:0]       beat_plan[$];
    bit               tx_idle_en = 1'b1;
    bit               rx_idle_en = 1'b1;
    int               settings = 0;

    hold_to_arm_launch_interlock #(
        .LED_COUNT(LEDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap(bit en);
        int r;
        if (!en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_beat(bit tick, logic [2:0] req, bit conn);
        beat_plan.push_back({3'b000, conn, req, tick});
    endfunction

    function automatic bit conn_mostly();
        return $urandom_range(0, 99) != 0;
    endfunction

    function automatic int hold_span(int unsigned hold);
        int unsigned base;
        base = (hold > 24) ? $urandom_range(4, 24) : hold;
        if ($urandom_range(0, 9) < 2)
            return $urandom_range(0, base);
        return base + $urandom_range(1, 3);
    endfunction

    function automatic void plan_ticks(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_beat(1'b0, REQ_NONE, 1'b1);
            if ($urandom_range(0, 19) == 0)
                push_beat(1'b1, 3'($urandom_range(5, 7)), conn_mostly());
            else
                push_beat(1'b1, REQ_NONE, conn_mostly());
        end
    endfunction

    // One arm, launch and burn sequence; some are cut short or disturbed.
    function automatic void plan_cycle(int unsigned hold);
        int unsigned burn;
        push_beat(1'($urandom_range(0, 1)), REQ_ARM_PRESS, 1'b1);
        plan_ticks(hold_span(hold));
        push_beat(1'($urandom_range(0, 1)), REQ_ARM_RELEASE, conn_mostly());
        if ($urandom_range(0, 9) == 0)
            return;
        push_beat(1'($urandom_range(0, 1)), REQ_LAUNCH_PRESS, 1'b1);
        if ($urandom_range(0, 14) == 0)
            push_beat(1'b0, REQ_ARM_PRESS, 1'b1);
        plan_ticks(hold_span(hold));
        push_beat(1'($urandom_range(0, 1)), REQ_LAUNCH_RELEASE, 1'b1);
        burn = ((hold > 24) ? 24 : hold) + 3;
        for (int i = 0; i < burn; i++)
        begin
            case ($urandom_range(0, 29))
                0:       push_beat(1'b1, REQ_LAUNCH_PRESS, 1'b1);
                1:       push_beat(1'b1, REQ_LAUNCH_RELEASE, 1'b1);
                2:       push_beat(1'b1, REQ_ARM_PRESS, 1'b1);
                3, 4:    push_beat(1'b1, REQ_NONE, 1'b0);
                default: push_beat(1'b1, REQ_NONE, 1'b1);
            endcase
        end
    endfunction

    function automatic void plan_noise(int n);
        for (int i = 0; i < n; i++)
            push_beat(1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? REQ_NONE : 3'($urandom_range(1, 7)),
                      $urandom_range(0, 5) != 0);
    endfunction

    function automatic void plan_random(int unsigned hold, int n);
        while (beat_plan.size() < n)
        begin
            if ($urandom_range(0, 9) < 7)
                plan_cycle(hold);
            else
                plan_noise($urandom_range(3, 12));
        end
    endfunction

    task automatic send_beat(input logic [7:0] beat);
        int gap;
        gap = pick_gap(tx_idle_en);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do @(posedge clk); while (!s_axis_tready);
        tracker.note_beat(beat[0], beat[3:1], beat[4]);
    endtask

    task automatic send_plan();
        foreach (beat_plan[i])
            send_beat(beat_plan[i]);
        s_axis_tvalid <= 1'b0;
        beat_plan.delete();
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_reg(idx, val);
    endtask

    task automatic configure(input int unsigned hold, input int unsigned base,
                             input int unsigned flash, input int unsigned fms,
                             input int unsigned sgap, input int unsigned lgap,
                             input bit idle_en);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
        write_reg(REG_HOLD_TIME, 16'(hold));
        write_reg(REG_BASE_BRIGHT, 16'(base));
        write_reg(REG_FLASH_BRIGHT, 16'(flash));
        write_reg(REG_FLASH_MS, 16'(fms));
        write_reg(REG_SHORT_GAP, 16'(sgap));
        write_reg(REG_LONG_GAP, 16'(lgap));
        write_reg(3'($urandom_range(6, 7)), 16'($urandom));
        cfg_valid <= 1'b0;
        settings++;
        tx_idle_en = idle_en;
        rx_idle_en = idle_en;
    endtask

    initial
    begin
        int stall_left;
        int hold_off;
        bit pressed;
        stall_left = 0;
        hold_off   = 0;
        pressed    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_panel(m_axis_tdata);
            // Hold off the result side once for a long stretch so the block fills up
            // and stops taking input beats.
            if (!pressed && tracker.checked == 450)
            begin
                hold_off = 300;
                pressed  = 1'b1;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0 && pick_gap(1'b1) > 0)
            begin
                stall_left = pick_gap(1'b1);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned hold;
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b0, REQ_ARM_PRESS, 1'b1);
        send_plan();

        configure(2, 7, 200, 0, 1, 2, 1'b1);
        push_beat(1'b0, REQ_ARM_PRESS, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b1, REQ_ARM_RELEASE, 1'b1);
        push_beat(1'b0, REQ_LAUNCH_PRESS, 1'b1);
        push_beat(1'b1, REQ_ARM_PRESS, 1'b1);
        push_beat(1'b1, 3'd5, 1'b1);
        push_beat(1'b0, 3'd6, 1'b0);
        push_beat(1'b1, 3'd7, 1'b1);
        push_beat(1'b0, REQ_ARM_PRESS, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b1, REQ_ARM_RELEASE, 1'b1);
        push_beat(1'b0, REQ_NONE, 1'b0);
        push_beat(1'b0, REQ_ARM_PRESS, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b1, REQ_ARM_RELEASE, 1'b1);
        push_beat(1'b0, REQ_LAUNCH_PRESS, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b1, REQ_LAUNCH_RELEASE, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b0);
        push_beat(1'b1, REQ_LAUNCH_PRESS, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        push_beat(1'b1, REQ_NONE, 1'b1);
        send_plan();

        configure(1, 255, 0, 0, 0, 0, 1'b1);
        plan_random(1, 200);
        send_plan();

        configure(0, $urandom_range(0, 255), $urandom_range(0, 255), 1, 2, 3, 1'b1);
        plan_random(0, 100);
        send_plan();

        hold = $urandom_range(3, 12);
        configure(hold, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20), 1'b1);
        plan_random(hold, 350);
        send_plan();

        configure(65535, 0, 255, 65535, 65535, 65535, 1'b1);
        plan_random(65535, 100);
        send_plan();

        hold = $urandom_range(10, 20);
        configure(hold, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 30), 1'b0);
        plan_random(hold, 350);
        send_plan();

        hold = $urandom_range(1, 8);
        configure(hold, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 12), 1'b1);
        plan_random(hold, 250);
        send_plan();

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Run covered %0d input beats and %0d result beats over %0d register settings,",
                 tracker.accepted, tracker.checked, settings);
        $display("with %0d arming holds and %0d ignitions completed.",
                 tracker.armings, tracker.ignitions);
        if (tracker.fails == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
